// ===== hdl/pese_pkg.sv =====
// shared types and constants of the prefix expression stack evaluator
package pese_pkg;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [31:0] POP_EMPTY_VAL = 32'hFFFF_FFFF;

  localparam int FLAG_UNDER = 0;
  localparam int FLAG_DIVZ  = 1;
  localparam int FLAG_OVER  = 2;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic               underflow_seen;
    logic               div_zero_seen;
    logic               overflow_seen;
  } out_item_t;

  typedef enum logic [2:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_POW
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP,
    S_POPW,
    S_EXEC,
    S_ALUW,
    S_PUSH,
    S_EMIT
  } seq_st_t;

  typedef enum logic [1:0] {
    POP_A,
    POP_B,
    POP_FIN
  } pop_t;

  typedef enum logic [2:0] {
    A_IDLE,
    A_DIV,
    A_DFIX,
    A_PMUL,
    A_PSQR
  } alu_st_t;

  typedef struct packed {
    logic        start;
    op_t         op;
    logic [31:0] a;
    logic [31:0] b;
  } alu_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] result;
  } alu_rsp_t;

endpackage

// ===== hdl/prefix_expression_stack_evaluator_core.sv =====
// top level: sequencer, operand stack and result register of the prefix evaluator
//
// channel  direction  handshake            payload
// in_      input      in_valid/in_ready    in_data  (in_item_t)
// out_     output     out_valid/out_ready  out_data (out_item_t)
//
// one transaction in at a time; in_ready is high only while the sequencer is idle
// digit: S_PUSH; ignored character: S_IDLE only; operator: two pops (S_POP, S_POPW),
// S_EXEC, S_ALUW, S_PUSH; the unit divides one quotient bit a cycle and powers
// by one shared multiplier, square and multiply per exponent bit; last char: pop, S_EMIT
// a finished result waits in the output register; only the next S_EMIT stalls on it
// reset empties the stack and clears the flags; stack ram contents are not cleared
module prefix_expression_stack_evaluator_core
  import pese_pkg::*;
#(
  parameter int STACK_DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W = $clog2(STACK_DEPTH);

  seq_st_t     state_r, state_nxt;
  pop_t        pop_r, pop_nxt;
  op_t         op_r, op_nxt;
  logic        last_r, last_nxt;
  logic [31:0] a_r, a_nxt;
  logic [31:0] b_r, b_nxt;
  logic [31:0] push_val_r, push_val_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [2:0]  flags_r, flags_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_data_r, out_data_nxt;

  logic [CNT_W-1:0]  cnt_dec;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [31:0]       ram_rdata;
  logic              pop_done;
  logic [31:0]       pop_val;
  logic [7:0]        ch;
  alu_req_t          alu_req;
  alu_rsp_t          alu_rsp;

  assign cnt_dec   = count_r - CNT_W'(1);
  assign ram_waddr = count_r[ADDR_W-1:0];
  assign ram_raddr = cnt_dec[ADDR_W-1:0];
  assign ch        = in_data.char_code;

  pese_ram #(
    .WIDTH (32),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (push_val_r),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  pese_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (alu_req),
    .rsp   (alu_rsp)
  );

  always_comb begin
    state_nxt     = state_r;
    pop_nxt       = pop_r;
    op_nxt        = op_r;
    last_nxt      = last_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    push_val_nxt  = push_val_r;
    count_nxt     = count_r;
    flags_nxt     = flags_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    ram_we        = 1'b0;
    pop_done      = 1'b0;
    pop_val       = ram_rdata;
    alu_req.start = 1'b0;
    alu_req.op    = op_r;
    alu_req.a     = a_r;
    alu_req.b     = b_r;
    in_ready      = (state_r == S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          last_nxt = in_data.last_char;
          if (ch >= CH_ZERO && ch <= CH_NINE) begin
            push_val_nxt = {24'd0, ch - CH_ZERO};
            state_nxt    = S_PUSH;
          end else if (ch == CH_PLUS || ch == CH_MINUS || ch == CH_STAR ||
                       ch == CH_SLASH || ch == CH_CARET) begin
            unique case (ch)
              CH_PLUS:  op_nxt = OP_ADD;
              CH_MINUS: op_nxt = OP_SUB;
              CH_STAR:  op_nxt = OP_MUL;
              CH_SLASH: op_nxt = OP_DIV;
              default:  op_nxt = OP_POW;
            endcase
            pop_nxt   = POP_A;
            state_nxt = S_POP;
          end else if (in_data.last_char) begin
            pop_nxt   = POP_FIN;
            state_nxt = S_POP;
          end
        end
      end
      S_POP: begin
        if (count_r == '0) begin
          flags_nxt[FLAG_UNDER] = 1'b1;
          pop_val  = POP_EMPTY_VAL;
          pop_done = 1'b1;
        end else begin
          count_nxt = cnt_dec;
          state_nxt = S_POPW;
        end
      end
      S_POPW: begin
        pop_done = 1'b1;
      end
      S_EXEC: begin
        if (op_r == OP_DIV && b_r == 32'd0) begin
          flags_nxt[FLAG_DIVZ] = 1'b1;
          if (last_r) begin
            pop_nxt   = POP_FIN;
            state_nxt = S_POP;
          end else begin
            state_nxt = S_IDLE;
          end
        end else begin
          alu_req.start = 1'b1;
          state_nxt     = S_ALUW;
        end
      end
      S_ALUW: begin
        if (alu_rsp.done) begin
          push_val_nxt = alu_rsp.result;
          state_nxt    = S_PUSH;
        end
      end
      S_PUSH: begin
        if (count_r == CNT_W'(STACK_DEPTH)) begin
          flags_nxt[FLAG_OVER] = 1'b1;
        end else begin
          ram_we    = 1'b1;
          count_nxt = count_r + CNT_W'(1);
        end
        if (last_r) begin
          pop_nxt   = POP_FIN;
          state_nxt = S_POP;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt               = 1'b1;
          out_data_nxt.value          = a_r;
          out_data_nxt.underflow_seen = flags_r[FLAG_UNDER];
          out_data_nxt.div_zero_seen  = flags_r[FLAG_DIVZ];
          out_data_nxt.overflow_seen  = flags_r[FLAG_OVER];
          count_nxt                   = '0;
          flags_nxt                   = '0;
          state_nxt                   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (pop_done) begin
      unique case (pop_r)
        POP_A: begin
          a_nxt     = pop_val;
          pop_nxt   = POP_B;
          state_nxt = S_POP;
        end
        POP_B: begin
          b_nxt     = pop_val;
          state_nxt = S_EXEC;
        end
        default: begin
          a_nxt     = pop_val;
          state_nxt = S_EMIT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      flags_r     <= '0;
      out_valid_r <= 1'b0;
      pop_r       <= POP_A;
      last_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      flags_r     <= flags_nxt;
      out_valid_r <= out_valid_nxt;
      pop_r       <= pop_nxt;
      last_r      <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    push_val_r <= push_val_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== hdl/pese_ram.sv =====
// generic single write, single read ram with registered read data
module pese_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/pese_alu.sv =====
// shared iterative arithmetic unit: add, subtract, multiply, divide, power
module pese_alu
  import pese_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  alu_st_t     st_r, st_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [31:0] base_r, base_nxt;
  logic [31:0] exp_r, exp_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        neg_r, neg_nxt;
  logic [31:0] res_r, res_nxt;
  logic        done_r, done_nxt;

  logic [31:0] mul_x, mul_y, prod;
  logic [32:0] rem_sh, diff;
  logic        ge;

  assign prod   = mul_x * mul_y;
  assign rem_sh = {rem_r, acc_r[31]};
  assign diff   = rem_sh - {1'b0, base_r};
  assign ge     = ~diff[32];

  always_comb begin
    st_nxt   = st_r;
    acc_nxt  = acc_r;
    base_nxt = base_r;
    exp_nxt  = exp_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    res_nxt  = res_r;
    done_nxt = 1'b0;
    mul_x    = req.a;
    mul_y    = req.b;
    unique case (st_r)
      A_IDLE: begin
        if (req.start) begin
          unique case (req.op)
            OP_ADD: begin
              res_nxt  = req.a + req.b;
              done_nxt = 1'b1;
            end
            OP_SUB: begin
              res_nxt  = req.a - req.b;
              done_nxt = 1'b1;
            end
            OP_MUL: begin
              res_nxt  = prod;
              done_nxt = 1'b1;
            end
            OP_DIV: begin
              acc_nxt  = req.a[31] ? (32'd0 - req.a) : req.a;
              base_nxt = req.b[31] ? (32'd0 - req.b) : req.b;
              rem_nxt  = '0;
              cnt_nxt  = '0;
              neg_nxt  = req.a[31] ^ req.b[31];
              st_nxt   = A_DIV;
            end
            OP_POW: begin
              if (req.b == 32'd0 || req.b[31]) begin
                res_nxt  = 32'd1;
                done_nxt = 1'b1;
              end else begin
                acc_nxt  = 32'd1;
                base_nxt = req.a;
                exp_nxt  = req.b;
                st_nxt   = A_PMUL;
              end
            end
            default: begin
              res_nxt  = '0;
              done_nxt = 1'b1;
            end
          endcase
        end
      end
      A_DIV: begin
        rem_nxt = ge ? diff[31:0] : rem_sh[31:0];
        acc_nxt = {acc_r[30:0], ge};
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          st_nxt = A_DFIX;
        end
      end
      A_DFIX: begin
        res_nxt  = neg_r ? (32'd0 - acc_r) : acc_r;
        done_nxt = 1'b1;
        st_nxt   = A_IDLE;
      end
      A_PMUL: begin
        mul_x = exp_r[0] ? acc_r : base_r;
        mul_y = base_r;
        if (exp_r[0]) begin
          acc_nxt = prod;
          if (exp_r == 32'd1) begin
            res_nxt  = prod;
            done_nxt = 1'b1;
            st_nxt   = A_IDLE;
          end else begin
            st_nxt = A_PSQR;
          end
        end else begin
          base_nxt = prod;
          exp_nxt  = {1'b0, exp_r[31:1]};
        end
      end
      A_PSQR: begin
        mul_x    = base_r;
        mul_y    = base_r;
        base_nxt = prod;
        exp_nxt  = {1'b0, exp_r[31:1]};
        st_nxt   = A_PMUL;
      end
      default: begin
        st_nxt = A_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= A_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r  <= acc_nxt;
    base_r <= base_nxt;
    exp_r  <= exp_nxt;
    rem_r  <= rem_nxt;
    cnt_r  <= cnt_nxt;
    neg_r  <= neg_nxt;
    res_r  <= res_nxt;
  end

  assign rsp.done   = done_r;
  assign rsp.result = res_r;

endmodule

// ===== dv/prefix_expression_stack_evaluator_core_tb.sv =====
// self-checking testbench of the prefix expression stack evaluator core
module prefix_expression_stack_evaluator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pese_pkg::*;

  localparam int STACK_DEPTH = 16;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned TAIL_CYCLES = 80;
  localparam int unsigned PHASE_CHARS = 450;
  localparam logic [7:0] CH_SPACE = 8'h20;

  class expr_scoreboard;
    logic [31:0] operand_stack [STACK_DEPTH];
    int unsigned depth_used = 0;
    logic [2:0] flags = '0;
    out_item_t pending_results [$];
    int unsigned mismatches = 0;
    int unsigned checked = 0;
    int unsigned under_cnt = 0;
    int unsigned divz_cnt = 0;
    int unsigned over_cnt = 0;

    function void push_operand(logic [31:0] v);
      if (depth_used >= STACK_DEPTH) begin
        flags[FLAG_OVER] = 1'b1;
      end else begin
        operand_stack[depth_used] = v;
        depth_used++;
      end
    endfunction

    function logic [31:0] pop_operand();
      if (depth_used == 0) begin
        flags[FLAG_UNDER] = 1'b1;
        return POP_EMPTY_VAL;
      end
      depth_used--;
      return operand_stack[depth_used];
    endfunction

    function logic [31:0] div_toward_zero(logic [31:0] num, logic [31:0] den);
      logic [31:0] q;
      q = (num[31] ? -num : num) / (den[31] ? -den : den);
      return (num[31] ^ den[31]) ? -q : q;
    endfunction

    function logic [31:0] power_wrapped(logic [31:0] base_v, logic [31:0] expo);
      logic [31:0] acc;
      logic [31:0] sq;
      logic [31:0] e;
      acc = 32'd1;
      sq = base_v;
      e = expo;
      if (e == 32'd0 || e[31]) return 32'd1;
      while (e != 32'd0) begin
        if (e[0]) acc = acc * sq;
        sq = sq * sq;
        e = e >> 1;
      end
      return acc;
    endfunction

    function void note_transaction(in_item_t t);
      logic [31:0] a;
      logic [31:0] b;
      out_item_t r;
      if (t.char_code >= CH_ZERO && t.char_code <= CH_NINE) begin
        push_operand({24'd0, t.char_code - CH_ZERO});
      end else begin
        case (t.char_code)
          CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_CARET: begin
            a = pop_operand();
            b = pop_operand();
            case (t.char_code)
              CH_PLUS:  push_operand(a + b);
              CH_MINUS: push_operand(a - b);
              CH_STAR:  push_operand(a * b);
              CH_SLASH: begin
                if (b == 32'd0) flags[FLAG_DIVZ] = 1'b1;
                else push_operand(div_toward_zero(a, b));
              end
              default:  push_operand(power_wrapped(a, b));
            endcase
          end
          default: ;
        endcase
      end
      if (t.last_char) begin
        r.value = pop_operand();
        r.underflow_seen = flags[FLAG_UNDER];
        r.div_zero_seen = flags[FLAG_DIVZ];
        r.overflow_seen = flags[FLAG_OVER];
        pending_results.push_back(r);
        depth_used = 0;
        flags = '0;
      end
    endfunction

    function void field_check(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_transaction(out_item_t got);
      out_item_t want;
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: result with nothing expected, expected none actual %0h", $time, got);
        return;
      end
      want = pending_results.pop_front();
      checked++;
      if (want.underflow_seen) under_cnt++;
      if (want.div_zero_seen) divz_cnt++;
      if (want.overflow_seen) over_cnt++;
      field_check("value", want.value, got.value);
      field_check("underflow_seen", 32'(want.underflow_seen), 32'(got.underflow_seen));
      field_check("div_zero_seen", 32'(want.div_zero_seen), 32'(got.div_zero_seen));
      field_check("overflow_seen", 32'(want.overflow_seen), 32'(got.overflow_seen));
    endfunction

    function int unsigned outstanding();
      return pending_results.size();
    endfunction
  endclass

  logic      clk;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  expr_scoreboard sb;
  int unsigned send_idle = 8;
  int unsigned recv_idle = 60;
  int unsigned chars_sent = 0;
  int unsigned active_sent = 0;
  int unsigned cycle_count = 0;

  prefix_expression_stack_evaluator_core #(
    .STACK_DEPTH(STACK_DEPTH)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_transaction(out_data);
    out_ready <= ($urandom_range(0, 99) >= recv_idle);
  end

  function automatic bit is_significant(logic [7:0] c);
    return (c >= CH_ZERO && c <= CH_NINE) || c == CH_PLUS || c == CH_MINUS ||
           c == CH_STAR || c == CH_SLASH || c == CH_CARET;
  endfunction

  function automatic logic [7:0] random_operator();
    case ($urandom_range(0, 4))
      0:       return CH_PLUS;
      1:       return CH_MINUS;
      2:       return CH_STAR;
      3:       return CH_SLASH;
      default: return CH_CARET;
    endcase
  endfunction

  function automatic logic [7:0] random_digit();
    return CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] random_filler();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    if (is_significant(c)) c = CH_SPACE;
    return c;
  endfunction

  task automatic send_char(logic [7:0] c, logic last);
    in_item_t t;
    t.char_code = c;
    t.last_char = last;
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= t;
    do @(posedge clk); while (!in_ready);
    sb.note_transaction(t);
    chars_sent++;
    if (is_significant(c) || last) active_sent++;
  endtask

  // characters in supply order, right to left of the written expression
  task automatic send_expression(int unsigned n_digits);
    int unsigned depth;
    int unsigned left;
    logic [7:0] c;
    logic fin;
    depth = 0;
    left = n_digits;
    while (left > 0 || depth > 1) begin
      if (left > 0 && (depth < 2 || $urandom_range(0, 99) < 55)) begin
        c = random_digit();
        left--;
        depth++;
      end else begin
        c = random_operator();
        depth--;
      end
      fin = (left == 0 && depth <= 1);
      if (!fin && $urandom_range(0, 99) < 4) send_char(random_filler(), 1'b0);
      send_char(c, fin);
    end
  endtask

  task automatic send_broken();
    int unsigned len;
    int unsigned pick;
    logic [7:0] c;
    len = $urandom_range(1, 8);
    for (int unsigned i = 0; i < len; i++) begin
      pick = $urandom_range(0, 9);
      if (pick < 5) c = random_digit();
      else if (pick < 9) c = random_operator();
      else c = random_filler();
      send_char(c, i == len - 1);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.outstanding() != 0);
  endtask

  initial begin
    int unsigned pick;
    int unsigned target;
    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // add on an empty stack, field extremes as fillers
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(CH_PLUS, 1'b1);
    // zero divisor
    send_char(CH_ZERO, 1'b0);
    send_char(CH_ZERO + 8'd7, 1'b0);
    send_char(CH_SLASH, 1'b1);
    // 2^31 divided by the -1 of an empty pop
    send_char(CH_ZERO + 8'd4, 1'b0);
    send_char(CH_NINE, 1'b0);
    send_char(CH_ZERO + 8'd3, 1'b0);
    send_char(CH_STAR, 1'b0);
    send_char(CH_PLUS, 1'b0);
    send_char(CH_ZERO + 8'd2, 1'b0);
    send_char(CH_CARET, 1'b0);
    send_char(CH_SLASH, 1'b1);
    // one push beyond a full stack
    for (int unsigned i = 0; i <= STACK_DEPTH; i++) begin
      send_char(CH_ZERO + 8'(i % 10), i == STACK_DEPTH);
    end
    drain_results();

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle = 8;
          recv_idle = 60;
        end
        1: begin
          send_idle = 60;
          recv_idle = 8;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      target = active_sent + PHASE_CHARS;
      while (active_sent < target) begin
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
          if ($urandom_range(0, 99) < 88) send_expression($urandom_range(1, 6));
          else send_expression($urandom_range(12, 20));
        end else if (pick < 92) begin
          send_broken();
        end else begin
          send_char(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
        end
      end
      drain_results();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("%0d characters driven (%0d digits, operators or end marks), %0d results checked",
             chars_sent, active_sent, sb.checked);
    $display("results with underflow %0d, divide by zero %0d, dropped push %0d",
             sb.under_cnt, sb.divz_cnt, sb.over_cnt);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/pese_pkg.sv
hdl/pese_ram.sv
hdl/pese_alu.sv
hdl/prefix_expression_stack_evaluator_core.sv
dv/prefix_expression_stack_evaluator_core_tb.sv
